// File: sv/tlg_pkg.sv
package tlg_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] COUNT_RESET = 7'd64;

    // Input beat fields
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL_WR,
        ST_CELL_RD,
        ST_COPY,
        ST_CALC
    } state_t;

    // Per-row sequence of the generation pass
    typedef enum logic [1:0] {
        PH_ABOVE,
        PH_MID,
        PH_BELOW,
        PH_WRITE
    } phase_t;

endpackage

// File: sv/toroidal_life_generation_core.sv
// Game of Life (B3/S23) on a torus of up to MAX_ROWS x MAX_COLS cells. The grid is
// kept as one row per memory word, MAX_COLS bits wide, with a second memory of the
// same shape holding the snapshot used by a generation. After reset a clearing pass
// writes one grid row per cycle over all MAX_ROWS rows; input beats are held off until
// it ends, configuration writes are taken at any time. A cell write or a cell read
// reads the row, then modifies and writes it back or selects the bit. An unused
// operation code completes from the idle state. A generation on an active area of nr
// rows first copies the rows into the snapshot, then, for each row, reads the rows
// above, at and below it through the single snapshot read port while all columns of
// the row are computed in parallel and written back. One beat is in progress at a
// time; its result sits in an output register.
module toroidal_life_generation_core
    import tlg_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       operation,
    input  logic [ADDR_W-1:0]     row,
    input  logic [ADDR_W-1:0]     col,
    input  logic                  cell_in,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  cell_out
);

    localparam int RAW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CAW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NR_W   = $clog2(MAX_ROWS + 1);
    localparam int NC_W   = $clog2(MAX_COLS + 1);

    // Memories
    logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] snap_mem [MAX_ROWS];

    logic                grid_we;
    logic [RAW-1:0]      grid_waddr;
    logic [MAX_COLS-1:0] grid_wdata;
    logic [RAW-1:0]      grid_raddr;
    logic [MAX_COLS-1:0] grid_rd_reg;

    logic                snap_we;
    logic [RAW-1:0]      snap_waddr;
    logic [RAW-1:0]      snap_raddr;
    logic [MAX_COLS-1:0] snap_rd_reg;

    // Control
    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [NR_W-1:0]     cnt_reg, cnt_next;
    logic [RAW-1:0]      calc_row_reg, calc_row_next;
    logic                out_valid_reg, out_valid_next;
    logic                cell_out_reg, cell_out_next;
    logic [CFG_DATA_W-1:0] row_count_reg, row_count_next;
    logic [CFG_DATA_W-1:0] col_count_reg, col_count_next;

    // Payload
    logic [RAW-1:0]      row_a_reg;
    logic [CAW-1:0]      col_a_reg;
    logic                cell_in_reg;
    logic                in_area_reg;
    logic [MAX_COLS-1:0] above_reg, above_next;
    logic [MAX_COLS-1:0] mid_reg, mid_next;

    logic                in_fire;
    logic                in_area;
    logic [NR_W-1:0]     nr;
    logic [NC_W-1:0]     nc;
    logic [CAW-1:0]      nc_m1;
    logic                last_row;
    logic [RAW-1:0]      up_row;
    logic [RAW-1:0]      down_row;
    logic [MAX_COLS-1:0] gen_row;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;

    // Active size: 0 acts as 1, above the maximum clamps
    always_comb
    begin
        if (row_count_reg == '0)
            nr = NR_W'(1);
        else if (int'(row_count_reg) > MAX_ROWS)
            nr = NR_W'(MAX_ROWS);
        else
            nr = NR_W'(row_count_reg);

        if (col_count_reg == '0)
            nc = NC_W'(1);
        else if (int'(col_count_reg) > MAX_COLS)
            nc = NC_W'(MAX_COLS);
        else
            nc = NC_W'(col_count_reg);
    end

    assign nc_m1    = CAW'(nc - NC_W'(1));
    assign in_area  = (int'(row) < int'(nr)) && (int'(col) < int'(nc));
    assign last_row = (int'(calc_row_reg) == int'(nr) - 1);
    assign up_row   = (calc_row_reg == '0) ? RAW'(nr - NR_W'(1)) : calc_row_reg - RAW'(1);
    assign down_row = last_row ? '0 : calc_row_reg + RAW'(1);

    // Next generation of one row; snap_rd_reg holds the row below in PH_WRITE
    always_comb
    begin
        logic       ul, um, ur, ml, mr, dl, dm, dr;
        logic [3:0] n;
        gen_row = mid_reg;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            um = above_reg[c];
            dm = snap_rd_reg[c];
            if (c == 0)
            begin
                ul = above_reg[nc_m1];
                ml = mid_reg[nc_m1];
                dl = snap_rd_reg[nc_m1];
            end
            else
            begin
                ul = above_reg[(c + MAX_COLS - 1) % MAX_COLS];
                ml = mid_reg[(c + MAX_COLS - 1) % MAX_COLS];
                dl = snap_rd_reg[(c + MAX_COLS - 1) % MAX_COLS];
            end
            if (CAW'(c) == nc_m1)
            begin
                ur = above_reg[0];
                mr = mid_reg[0];
                dr = snap_rd_reg[0];
            end
            else
            begin
                ur = above_reg[(c + 1) % MAX_COLS];
                mr = mid_reg[(c + 1) % MAX_COLS];
                dr = snap_rd_reg[(c + 1) % MAX_COLS];
            end
            n = 4'(ul) + 4'(um) + 4'(ur) + 4'(ml) + 4'(mr) + 4'(dl) + 4'(dm) + 4'(dr);
            if (c < int'(nc))
                gen_row[c] = (n == 4'd3) || (mid_reg[c] && (n == 4'd2));
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (int'(cnt_reg) == MAX_ROWS - 1)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_fire)
                begin
                    case (op_t'(operation))
                        OP_WRITE: state_next = ST_CELL_WR;
                        OP_READ:  state_next = ST_CELL_RD;
                        OP_STEP:  state_next = ST_COPY;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            ST_CELL_WR,
            ST_CELL_RD:
                state_next = ST_IDLE;
            ST_COPY:
                if (cnt_reg == nr)
                    state_next = ST_CALC;
            ST_CALC:
                if (phase_reg == PH_WRITE && last_row)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        calc_row_next  = calc_row_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cell_out_next  = cell_out_reg;
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        above_next     = above_reg;
        mid_next       = mid_reg;

        grid_we    = 1'b0;
        grid_waddr = row_a_reg;
        grid_wdata = grid_rd_reg;
        grid_raddr = RAW'(row);
        snap_we    = 1'b0;
        snap_waddr = RAW'(cnt_reg - NR_W'(1));
        snap_raddr = calc_row_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW_COUNT: row_count_next = cfg_data;
                REG_COL_COUNT: col_count_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                grid_we    = 1'b1;
                grid_waddr = RAW'(cnt_reg);
                grid_wdata = '0;
                cnt_next   = cnt_reg + NR_W'(1);
            end
            ST_IDLE:
            begin
                cnt_next      = '0;
                calc_row_next = '0;
                phase_next    = PH_ABOVE;
                if (in_fire && op_t'(operation) != OP_WRITE && op_t'(operation) != OP_READ
                    && op_t'(operation) != OP_STEP)
                begin
                    out_valid_next = 1'b1;
                    cell_out_next  = 1'b0;
                end
            end
            ST_CELL_WR:
            begin
                grid_we                = in_area_reg;
                grid_wdata[col_a_reg]  = cell_in_reg;
                out_valid_next         = 1'b1;
                cell_out_next          = 1'b0;
            end
            ST_CELL_RD:
            begin
                out_valid_next = 1'b1;
                cell_out_next  = in_area_reg && grid_rd_reg[col_a_reg];
            end
            ST_COPY:
            begin
                // read grid row cnt, write the row read in the previous cycle
                grid_raddr = RAW'(cnt_reg);
                snap_we    = (cnt_reg != '0);
                if (cnt_reg != nr)
                    cnt_next = cnt_reg + NR_W'(1);
            end
            ST_CALC:
            begin
                case (phase_reg)
                    PH_ABOVE:
                    begin
                        snap_raddr = up_row;
                        phase_next = PH_MID;
                    end
                    PH_MID:
                    begin
                        snap_raddr = calc_row_reg;
                        above_next = snap_rd_reg;
                        phase_next = PH_BELOW;
                    end
                    PH_BELOW:
                    begin
                        snap_raddr = down_row;
                        mid_next   = snap_rd_reg;
                        phase_next = PH_WRITE;
                    end
                    PH_WRITE:
                    begin
                        grid_we       = 1'b1;
                        grid_waddr    = calc_row_reg;
                        grid_wdata    = gen_row;
                        phase_next    = PH_ABOVE;
                        calc_row_next = calc_row_reg + RAW'(1);
                        if (last_row)
                        begin
                            out_valid_next = 1'b1;
                            cell_out_next  = 1'b0;
                        end
                    end
                    default:
                        phase_next = PH_ABOVE;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_ABOVE;
            cnt_reg       <= '0;
            calc_row_reg  <= '0;
            out_valid_reg <= 1'b0;
            cell_out_reg  <= 1'b0;
            row_count_reg <= COUNT_RESET;
            col_count_reg <= COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            calc_row_reg  <= calc_row_next;
            out_valid_reg <= out_valid_next;
            cell_out_reg  <= cell_out_next;
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            row_a_reg   <= RAW'(row);
            col_a_reg   <= CAW'(col);
            cell_in_reg <= cell_in;
            in_area_reg <= in_area;
        end
        above_reg <= above_next;
        mid_reg   <= mid_next;
    end

    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[grid_waddr] <= grid_wdata;
        grid_rd_reg <= grid_mem[grid_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (snap_we)
            snap_mem[snap_waddr] <= grid_rd_reg;
        snap_rd_reg <= snap_mem[snap_raddr];
    end

endmodule

// File: tb/toroidal_life_generation_core_tb.sv
`timescale 1ns / 100ps

module toroidal_life_generation_core_tb;
    import tlg_pkg::*;

    localparam int GRID_ROWS      = 64;
    localparam int GRID_COLS      = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRESSURE_HOLD  = 300;
    localparam int DRAIN_CYCLES   = 40;

    // operation code 3 is not in op_t; the block must treat it as a no-op
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [OP_W-1:0]       operation;
    logic [ADDR_W-1:0]     row;
    logic [ADDR_W-1:0]     col;
    logic                  cell_in;
    logic                  out_valid;
    logic                  out_ready;
    logic                  cell_out;

    toroidal_life_generation_core #(
        .MAX_ROWS (GRID_ROWS),
        .MAX_COLS (GRID_COLS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .row       (row),
        .col       (col),
        .cell_in   (cell_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cell_out  (cell_out)
    );

    // Shadow copy of the grid and the size registers
    bit [GRID_COLS-1:0]    life_grid [GRID_ROWS];
    logic [CFG_DATA_W-1:0] row_count_reg = COUNT_RESET;
    logic [CFG_DATA_W-1:0] col_count_reg = COUNT_RESET;

    logic pending_cells [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;

    int mismatch_count = 0;
    int results_seen   = 0;
    int n_writes       = 0;
    int n_reads        = 0;
    int n_generations  = 0;
    int n_spare        = 0;
    int n_cfg_writes   = 0;
    int idle_cycles    = 0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned active_extent(input logic [CFG_DATA_W-1:0] count_val,
                                                  input int unsigned limit);
        if (count_val == 0)
            return 1;
        return (count_val > limit) ? limit : count_val;
    endfunction

    function automatic void next_generation();
        int unsigned nr;
        int unsigned nc;
        int unsigned rr;
        int unsigned cc;
        int unsigned neigh;
        bit [GRID_COLS-1:0] snap [GRID_ROWS];
        nr = active_extent(row_count_reg, GRID_ROWS);
        nc = active_extent(col_count_reg, GRID_COLS);
        for (int r = 0; r < GRID_ROWS; r++)
            snap[r] = life_grid[r];
        for (int unsigned r = 0; r < nr; r++) begin
            for (int unsigned c = 0; c < nc; c++) begin
                neigh = 0;
                // narrow grids wrap onto the cell itself; only the center is skipped
                for (int unsigned dr = 0; dr < 3; dr++) begin
                    rr = (r + nr - 1 + dr) % nr;
                    for (int unsigned dc = 0; dc < 3; dc++) begin
                        if (dr == 1 && dc == 1)
                            continue;
                        cc = (c + nc - 1 + dc) % nc;
                        neigh += snap[rr][cc];
                    end
                end
                life_grid[r][c] = (neigh == 3) || (snap[r][c] && neigh == 2);
            end
        end
    endfunction

    function automatic logic predict_cell(input logic [OP_W-1:0] op,
                                          input logic [ADDR_W-1:0] r,
                                          input logic [ADDR_W-1:0] c,
                                          input logic v);
        logic in_area;
        in_area = (r < active_extent(row_count_reg, GRID_ROWS)) &&
                  (c < active_extent(col_count_reg, GRID_COLS));
        case (op)
            OP_WRITE: if (in_area) life_grid[r][c] = v;
            OP_READ:  if (in_area) return life_grid[r][c];
            OP_STEP:  next_generation();
            default:  ;
        endcase
        return 1'b0;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_count();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1;
            2:       return COUNT_RESET;
            3:       return CFG_DATA_W'($urandom_range(65, 127));
            4:       return 2;
            default: return CFG_DATA_W'($urandom_range(3, 12));
        endcase
    endfunction

    // Entered right after a falling edge; returns at a falling edge with in_valid still high
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] r,
                             input logic [ADDR_W-1:0] c, input logic v);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        row       <= r;
        col       <= c;
        cell_in   <= v;
        do
            @(posedge clk);
        while (!in_ready);
        pending_cells.push_back(predict_cell(op, r, c, v));
        case (op)
            OP_WRITE: n_writes++;
            OP_READ:  n_reads++;
            OP_STEP:  n_generations++;
            default:  n_spare++;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_ROW_COUNT)
            row_count_reg = data;
        else
            col_count_reg = data;
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_reset_state();
        send_beat(OP_READ, 0, 0, 0);
        send_beat(OP_READ, GRID_ROWS - 1, GRID_COLS - 1, 0);
        send_beat(OP_SPARE, '1, '1, 1'b1);
    endtask

    task automatic test_cell_extremes();
        send_beat(OP_WRITE, 0, 0, 1'b1);
        send_beat(OP_WRITE, GRID_ROWS - 1, GRID_COLS - 1, 1'b1);
        send_beat(OP_WRITE, 0, GRID_COLS - 1, 1'b1);
        send_beat(OP_WRITE, GRID_ROWS - 1, 0, 1'b1);
        send_beat(OP_READ, GRID_ROWS - 1, GRID_COLS - 1, 0);
        send_beat(OP_READ, 0, GRID_COLS - 1, 0);
        send_beat(OP_WRITE, GRID_ROWS - 1, 0, 1'b0);
        send_beat(OP_READ, GRID_ROWS - 1, 0, 0);
    endtask

    // Out-of-range counts, addresses outside the active area, narrow tori,
    // cells outside the area kept across a generation and a resize
    task automatic test_size_registers();
        wait_drained();
        cfg_write(REG_ROW_COUNT, 0);
        cfg_write(REG_COL_COUNT, 127);
        send_beat(OP_WRITE, 1, 5, 1'b1);
        send_beat(OP_READ, 1, 5, 0);
        send_beat(OP_WRITE, 0, 10, 1'b1);
        send_beat(OP_WRITE, 0, 11, 1'b1);
        send_beat(OP_STEP, 0, 0, 0);
        send_beat(OP_READ, 0, 11, 0);
        wait_drained();
        cfg_write(REG_ROW_COUNT, 2);
        cfg_write(REG_COL_COUNT, 2);
        send_beat(OP_WRITE, 0, 0, 1'b1);
        send_beat(OP_STEP, 0, 0, 0);
        send_beat(OP_READ, 0, 0, 0);
        send_beat(OP_READ, 1, 1, 0);
        wait_drained();
        cfg_write(REG_ROW_COUNT, COUNT_RESET);
        cfg_write(REG_COL_COUNT, COUNT_RESET);
        send_beat(OP_READ, GRID_ROWS - 1, GRID_COLS - 1, 0);
        send_beat(OP_STEP, 0, 0, 0);
        send_beat(OP_READ, 0, GRID_COLS - 1, 0);
    endtask

    // Receiver holds off while beats keep coming, so the input side backs up
    task automatic test_backpressure();
        int unsigned nr;
        int unsigned nc;
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        nr = active_extent(row_count_reg, GRID_ROWS);
        nc = active_extent(col_count_reg, GRID_COLS);
        hold_request = PRESSURE_HOLD;
        repeat (6) begin
            send_beat($urandom_range(1) ? OP_WRITE : OP_READ,
                      ADDR_W'($urandom_range(nr - 1)), ADDR_W'($urandom_range(nc - 1)),
                      1'($urandom_range(1)));
        end
        send_beat(OP_STEP, 0, 0, 0);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int sent;
        int unsigned nr;
        int unsigned nc;
        wait_drained();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        cfg_write(REG_ROW_COUNT, random_count());
        cfg_write(REG_COL_COUNT, random_count());
        nr = active_extent(row_count_reg, GRID_ROWS);
        nc = active_extent(col_count_reg, GRID_COLS);
        sent = 0;
        while (sent < n_items) begin
            // seed a few cells, run some generations, read back, then noise
            repeat ($urandom_range(2, 6)) begin
                send_beat(OP_WRITE, ADDR_W'($urandom_range(nr - 1)),
                          ADDR_W'($urandom_range(nc - 1)), $urandom_range(3) != 0);
                sent++;
            end
            repeat ($urandom_range(1, 3)) begin
                send_beat(OP_STEP, ADDR_W'($urandom_range(63)), ADDR_W'($urandom_range(63)),
                          1'($urandom_range(1)));
                sent++;
            end
            repeat ($urandom_range(1, 4)) begin
                send_beat(OP_READ, ADDR_W'($urandom_range(nr - 1)),
                          ADDR_W'($urandom_range(nc - 1)), 1'($urandom_range(1)));
                sent++;
            end
            repeat ($urandom_range(0, 2)) begin
                case ($urandom_range(2))
                    0:       send_beat(OP_READ, ADDR_W'($urandom_range(63)),
                                       ADDR_W'($urandom_range(63)), 1'($urandom_range(1)));
                    1:       send_beat(OP_WRITE, ADDR_W'($urandom_range(63)),
                                       ADDR_W'($urandom_range(63)), 1'($urandom_range(1)));
                    default: send_beat(OP_SPARE, ADDR_W'($urandom_range(63)),
                                       ADDR_W'($urandom_range(63)), 1'($urandom_range(1)));
                endcase
            end
        end
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        logic want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_cells.size() == 0) begin
                $display("%0t: result beat with nothing pending, expected none, got cell_out=%0b",
                         $time, cell_out);
                mismatch_count++;
            end else begin
                want = pending_cells.pop_front();
                if (cell_out !== want) begin
                    $display("%0t: cell_out mismatch on result %0d: expected %0b, got %0b",
                             $time, results_seen, want, cell_out);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ROW_COUNT;
        cfg_data  = '0;
        in_valid  = 1'b0;
        operation = OP_WRITE;
        row       = '0;
        col       = '0;
        cell_in   = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_cell_extremes();
        test_size_registers();
        test_random_traffic(0, 0, 20);
        test_backpressure();
        test_random_traffic(55, 0, 20);
        test_random_traffic(0, 55, 20);
        test_random_traffic(28, 28, 20);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d writes, %0d reads, %0d generations, %0d spare-code beats",
                 n_writes, n_reads, n_generations, n_spare);
        $display("over %0d size register writes; %0d results checked, %0d mismatches",
                 n_cfg_writes, results_seen, mismatch_count);
        if (mismatch_count == 0 && pending_cells.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
